// ===== hdl/icns_rle_pkg.sv =====
package icns_rle_pkg;

   // Defaults for the top-level parameters
   localparam int LITERAL_CHUNK_MAX = 128;
   localparam int RUN_MAX           = 130;

   // Op queue between the front and the back
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths
   localparam int BYTE_W     = 8;
   localparam int PIXEL_W    = 32;
   localparam int RUN_LEN_W  = 8;
   localparam int OUT_BYTES_W = 64;
   localparam int COUNT_W    = 4;
   localparam int RSP_DATA_W = 72;
   localparam int WORD_BYTES = 8;

   // Run header is (length - RUN_MIN) + RUN_HDR_BASE
   localparam int RUN_MIN             = 3;
   localparam logic [7:0] RUN_HDR_BASE = 8'h80;

   localparam logic [1:0] CHAN_RESET = 2'd1;

   typedef enum logic {
      OP_CLOSE,
      OP_END
   } op_kind_type;

   // One op for the back: close a run, or end the current pixel's output
   typedef struct packed {
      op_kind_type          kind;
      logic [RUN_LEN_W-1:0] len;
      logic [BYTE_W-1:0]    value;
      logic                 last;
   } op_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_LIT,
      BE_CH_HDR,
      BE_CH_DATA,
      BE_RUN_HDR,
      BE_RUN_VAL,
      BE_END
   } back_state_type;

   // Byte request from the back to the word packer
   typedef struct packed {
      logic              put;
      logic              fin;
      logic              last;
      logic [BYTE_W-1:0] data;
   } pack_req_type;

endpackage

// ===== hdl/icns_channel_rle_encoder_unit.sv =====
// Channel     | Direction | Payload
// req_*       | in        | tdata[31:0] pixel_word, tlast last_pixel
// rsp_*       | out       | tdata[63:0] out_bytes, [67:64] byte_count, tlast stream_end
// csr_*       | in        | channel_select, written when csr_we is high
//
// The front takes a new pixel only once every op of the last one is in the op
// queue: it accepts the pixel, then pushes its ops (run close, run close at cap or
// end, end of pixel) in order while the queue has room. The back takes each op,
// stores literal bytes, passes output bytes to the packer and closes the pixel's
// output; a literal chunk is its count minus one, then its bytes, read from the
// literal store one byte a cycle while the packer accepts. Reset is synchronous;
// the literal store needs no clearing pass. A stall on rsp holds the back at the
// packer; the queue keeps the front going until it fills.
module icns_channel_rle_encoder_unit #(
   parameter int LITERAL_CHUNK_MAX = icns_rle_pkg::LITERAL_CHUNK_MAX,
   parameter int RUN_MAX           = icns_rle_pkg::RUN_MAX
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [icns_rle_pkg::PIXEL_W-1:0]    req_tdata,  // [31:0] pixel_word
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [63:0] out_bytes, [67:64] byte_count, [71:68] zero
   output logic [icns_rle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_wdata
);

   logic [1:0] chan_ff, chan_in;

   logic                       q_push;
   icns_rle_pkg::op_type       q_push_op;
   logic                       q_full;
   logic                       q_pop;
   icns_rle_pkg::op_type       q_pop_op;
   logic                       q_empty;
   icns_rle_pkg::pack_req_type pk_req;
   logic                       pk_acc;

   assign chan_in = csr_we ? csr_wdata : chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= icns_rle_pkg::CHAN_RESET;
      end else begin
         chan_ff <= chan_in;
      end
   end

   icns_rle_front #(
      .RUN_MAX (RUN_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .chan_sel  (chan_ff),
      .pix_valid (req_tvalid),
      .pix_ready (req_tready),
      .pix_word  (req_tdata),
      .pix_last  (req_tlast),
      .q_push    (q_push),
      .q_op      (q_push_op),
      .q_full    (q_full)
   );

   icns_rle_queue #(
      .DEPTH (icns_rle_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_push_op),
      .full    (q_full),
      .pop     (q_pop),
      .pop_op  (q_pop_op),
      .empty   (q_empty)
   );

   icns_rle_back #(
      .LITERAL_CHUNK_MAX (LITERAL_CHUNK_MAX)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_op    (q_pop_op),
      .q_pop   (q_pop),
      .pk_req  (pk_req),
      .pk_acc  (pk_acc)
   );

   icns_rle_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .pk_req     (pk_req),
      .pk_acc     (pk_acc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[67:64] != 4'd0) && (rsp_tdata[67:64] <= 4'd8))
      else $error("word byte count out of range");

   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[67:64] != 4'd8)) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("bytes past the count of a short word are not zero");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("front took a pixel while its ops were still pending");
`endif

endmodule

// ===== hdl/icns_rle_front.sv =====
module icns_rle_front #(
   parameter int RUN_MAX = icns_rle_pkg::RUN_MAX
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       chan_sel,
   input  logic                             pix_valid,
   output logic                             pix_ready,
   input  logic [icns_rle_pkg::PIXEL_W-1:0] pix_word,
   input  logic                             pix_last,
   output logic                             q_push,
   output icns_rle_pkg::op_type             q_op,
   input  logic                             q_full
);

   localparam int LW = icns_rle_pkg::RUN_LEN_W;
   localparam int BW = icns_rle_pkg::BYTE_W;

   logic [BW-1:0]        run_val_ff, run_val_in;
   logic [LW-1:0]        run_len_ff, run_len_in;
   logic [2:0]           pend_ff, pend_in;
   icns_rle_pkg::op_type pend_op_ff [3];
   icns_rle_pkg::op_type pend_op_in [3];

   logic          accept;
   logic [BW-1:0] sel_byte;
   logic          same;
   logic [LW-1:0] len_new;
   logic [BW-1:0] val_new;
   logic          cap;
   logic [1:0]    head;

   assign pix_ready = (pend_ff == 3'b000) && !reset;
   assign accept    = pix_valid && pix_ready;
   assign sel_byte  = pix_word[{~chan_sel, 3'b000} +: BW];
   assign same      = (run_len_ff != '0) && (sel_byte == run_val_ff);
   assign len_new   = same ? run_len_ff + LW'(1) : LW'(1);
   assign val_new   = same ? run_val_ff : sel_byte;
   assign cap       = (len_new >= LW'(RUN_MAX));

   // oldest pending op first
   assign head   = pend_ff[0] ? 2'd0 : (pend_ff[1] ? 2'd1 : 2'd2);
   assign q_push = (pend_ff != 3'b000) && !q_full;
   assign q_op   = pend_op_ff[head];

   always_comb begin
      run_val_in = run_val_ff;
      run_len_in = run_len_ff;
      pend_in    = pend_ff;
      pend_op_in = pend_op_ff;
      if (q_push) begin
         pend_in[head] = 1'b0;
      end
      if (accept) begin
         // close the run that this byte breaks
         pend_in[0]          = !same && (run_len_ff != '0);
         pend_op_in[0].kind  = icns_rle_pkg::OP_CLOSE;
         pend_op_in[0].len   = run_len_ff;
         pend_op_in[0].value = run_val_ff;
         pend_op_in[0].last  = 1'b0;
         // close the current run at the cap or at the end of the stream
         pend_in[1]          = cap || pix_last;
         pend_op_in[1].kind  = icns_rle_pkg::OP_CLOSE;
         pend_op_in[1].len   = len_new;
         pend_op_in[1].value = val_new;
         pend_op_in[1].last  = 1'b0;
         pend_in[2]          = 1'b1;
         pend_op_in[2].kind  = icns_rle_pkg::OP_END;
         pend_op_in[2].len   = '0;
         pend_op_in[2].value = '0;
         pend_op_in[2].last  = pix_last;
         if (pix_last) begin
            run_val_in = '0;
            run_len_in = '0;
         end else begin
            run_val_in = val_new;
            run_len_in = cap ? '0 : len_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_val_ff <= '0;
         run_len_ff <= '0;
         pend_ff    <= '0;
      end else begin
         run_val_ff <= run_val_in;
         run_len_ff <= run_len_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_op_ff <= pend_op_in;
   end

endmodule

// ===== hdl/icns_rle_queue.sv =====
module icns_rle_queue #(
   parameter int DEPTH = icns_rle_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  icns_rle_pkg::op_type push_op,
   output logic                 full,
   input  logic                 pop,
   output icns_rle_pkg::op_type pop_op,
   output logic                 empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   icns_rle_pkg::op_type slot_ff [DEPTH];
   logic [AW:0]          wr_ptr_ff, wr_ptr_in;
   logic [AW:0]          rd_ptr_ff, rd_ptr_in;

   assign empty  = (wr_ptr_ff == rd_ptr_ff);
   assign full   = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) &&
                   (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign pop_op = slot_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = (push && !full) ? wr_ptr_ff + (AW+1)'(1) : wr_ptr_ff;
   assign rd_ptr_in = (pop && !empty) ? rd_ptr_ff + (AW+1)'(1) : rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff[AW-1:0]] <= push_op;
      end
   end

endmodule

// ===== hdl/icns_rle_back.sv =====
module icns_rle_back #(
   parameter int LITERAL_CHUNK_MAX = icns_rle_pkg::LITERAL_CHUNK_MAX
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  icns_rle_pkg::op_type       q_op,
   output logic                       q_pop,
   output icns_rle_pkg::pack_req_type pk_req,
   input  logic                       pk_acc
);

   localparam int CW = $clog2(LITERAL_CHUNK_MAX + 1);
   localparam int AW = (LITERAL_CHUNK_MAX > 1) ? $clog2(LITERAL_CHUNK_MAX) : 1;
   localparam int LW = icns_rle_pkg::RUN_LEN_W;
   localparam int BW = icns_rle_pkg::BYTE_W;

   icns_rle_pkg::back_state_type state_ff, state_in;
   icns_rle_pkg::back_state_type ret_ff, ret_in;
   logic [LW-1:0] len_ff, len_in;
   logic [BW-1:0] val_ff, val_in;
   logic          last_ff, last_in;
   logic [1:0]    rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [BW-1:0] rd_data_ff;
   logic [BW-1:0] lit_mem [LITERAL_CHUNK_MAX];

   logic [CW-1:0] cnt_inc;
   logic [CW-1:0] idx_inc;
   logic          chunk_full;
   logic          chunk_done;
   logic          more_lit;
   logic          wr_en;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   assign cnt_inc    = cnt_ff + CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign chunk_full = (cnt_inc == CW'(LITERAL_CHUNK_MAX));
   assign chunk_done = (idx_inc == cnt_ff);
   assign more_lit   = (rem_ff != 2'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         icns_rle_pkg::BE_IDLE: begin
            if (!q_empty) begin
               unique case (q_op.kind)
                  icns_rle_pkg::OP_END: begin
                     if (q_op.last && (cnt_ff != '0)) begin
                        state_in = icns_rle_pkg::BE_CH_HDR;
                        ret_in   = icns_rle_pkg::BE_END;
                     end else begin
                        state_in = icns_rle_pkg::BE_END;
                     end
                  end
                  icns_rle_pkg::OP_CLOSE: begin
                     if (q_op.len >= LW'(icns_rle_pkg::RUN_MIN)) begin
                        if (cnt_ff != '0) begin
                           state_in = icns_rle_pkg::BE_CH_HDR;
                           ret_in   = icns_rle_pkg::BE_RUN_HDR;
                        end else begin
                           state_in = icns_rle_pkg::BE_RUN_HDR;
                        end
                     end else begin
                        state_in = icns_rle_pkg::BE_LIT;
                     end
                  end
                  default: state_in = icns_rle_pkg::BE_IDLE;
               endcase
            end
         end
         icns_rle_pkg::BE_LIT: begin
            if (chunk_full) begin
               state_in = icns_rle_pkg::BE_CH_HDR;
               ret_in   = more_lit ? icns_rle_pkg::BE_LIT : icns_rle_pkg::BE_IDLE;
            end else begin
               state_in = more_lit ? icns_rle_pkg::BE_LIT : icns_rle_pkg::BE_IDLE;
            end
         end
         icns_rle_pkg::BE_CH_HDR: begin
            if (pk_acc) state_in = icns_rle_pkg::BE_CH_DATA;
         end
         icns_rle_pkg::BE_CH_DATA: begin
            if (pk_acc && chunk_done) state_in = ret_ff;
         end
         icns_rle_pkg::BE_RUN_HDR: begin
            if (pk_acc) state_in = icns_rle_pkg::BE_RUN_VAL;
         end
         icns_rle_pkg::BE_RUN_VAL: begin
            if (pk_acc) state_in = icns_rle_pkg::BE_IDLE;
         end
         icns_rle_pkg::BE_END: begin
            if (pk_acc) state_in = icns_rle_pkg::BE_IDLE;
         end
         default: state_in = icns_rle_pkg::BE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop   = 1'b0;
      pk_req  = '0;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      rd_addr = idx_inc[AW-1:0];
      unique case (state_ff)
         icns_rle_pkg::BE_IDLE: begin
            q_pop = !q_empty;
         end
         icns_rle_pkg::BE_LIT: begin
            wr_en = 1'b1;
         end
         icns_rle_pkg::BE_CH_HDR: begin
            pk_req.put  = 1'b1;
            pk_req.data = BW'(cnt_ff - CW'(1));
            rd_en       = pk_acc;
            rd_addr     = '0;
         end
         icns_rle_pkg::BE_CH_DATA: begin
            pk_req.put  = 1'b1;
            pk_req.data = rd_data_ff;
            rd_en       = pk_acc && !chunk_done;
         end
         icns_rle_pkg::BE_RUN_HDR: begin
            pk_req.put  = 1'b1;
            pk_req.data = BW'(len_ff - LW'(icns_rle_pkg::RUN_MIN)) +
                          icns_rle_pkg::RUN_HDR_BASE;
         end
         icns_rle_pkg::BE_RUN_VAL: begin
            pk_req.put  = 1'b1;
            pk_req.data = val_ff;
         end
         icns_rle_pkg::BE_END: begin
            pk_req.fin  = 1'b1;
            pk_req.last = last_ff;
         end
         default: q_pop = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      len_in  = len_ff;
      val_in  = val_ff;
      last_in = last_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      if (q_pop) begin
         len_in  = q_op.len;
         val_in  = q_op.value;
         last_in = q_op.last;
         rem_in  = q_op.len[1:0];
      end
      if (wr_en) begin
         cnt_in = cnt_inc;
         rem_in = rem_ff - 2'd1;
      end
      if ((state_ff == icns_rle_pkg::BE_CH_HDR) && pk_acc) begin
         idx_in = '0;
      end
      if ((state_ff == icns_rle_pkg::BE_CH_DATA) && pk_acc) begin
         if (chunk_done) cnt_in = '0;
         else idx_in = idx_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= icns_rle_pkg::BE_IDLE;
         ret_ff   <= icns_rle_pkg::BE_IDLE;
         cnt_ff   <= '0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      val_ff  <= val_in;
      last_ff <= last_in;
      idx_ff  <= idx_in;
   end

   // literal store, held read data while the packer stalls
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lit_mem[cnt_ff[AW-1:0]] <= val_ff;
      end
      if (rd_en) begin
         rd_data_ff <= lit_mem[rd_addr];
      end
   end

endmodule

// ===== hdl/icns_rle_pack.sv =====
module icns_rle_pack (
   input  logic                                clock,
   input  logic                                reset,
   input  icns_rle_pkg::pack_req_type          pk_req,
   output logic                                pk_acc,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [icns_rle_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int WW = icns_rle_pkg::OUT_BYTES_W;
   localparam int CW = icns_rle_pkg::COUNT_W;
   localparam int BW = icns_rle_pkg::BYTE_W;
   localparam int PAD_W = icns_rle_pkg::RSP_DATA_W - WW - CW;
   localparam logic [CW-1:0] FULL = CW'(icns_rle_pkg::WORD_BYTES);

   logic [WW-1:0] pack_ff, pack_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          out_valid_ff, out_valid_in;
   logic [WW-1:0] out_bytes_ff, out_bytes_in;
   logic [CW-1:0] out_cnt_ff, out_cnt_in;
   logic          out_end_ff, out_end_in;

   logic out_free;
   logic need_push;
   logic load;
   logic load_end;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign need_push = (pk_req.put && (cnt_ff == FULL)) ||
                      (pk_req.fin && (cnt_ff != '0));
   assign pk_acc    = !need_push || out_free;

   always_comb begin
      pack_in  = pack_ff;
      cnt_in   = cnt_ff;
      load     = 1'b0;
      load_end = 1'b0;
      if (pk_acc) begin
         if (pk_req.put) begin
            // a full word leaves when another byte arrives or when the pixel's output closes
            load = (cnt_ff == FULL);
            if ((cnt_ff == '0) || (cnt_ff == FULL)) begin
               pack_in = {pk_req.data, (WW-BW)'(0)};
               cnt_in  = CW'(1);
            end else begin
               pack_in[{~cnt_ff[2:0], 3'b000} +: BW] = pk_req.data;
               cnt_in = cnt_ff + CW'(1);
            end
         end else if (pk_req.fin) begin
            load     = (cnt_ff != '0);
            load_end = pk_req.last;
            cnt_in   = '0;
         end
      end
   end

   always_comb begin
      out_bytes_in = out_bytes_ff;
      out_cnt_in   = out_cnt_ff;
      out_end_in   = out_end_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (load) begin
         out_valid_in = 1'b1;
         out_bytes_in = pack_ff;
         out_cnt_in   = cnt_ff;
         out_end_in   = load_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff      <= pack_in;
      out_bytes_ff <= out_bytes_in;
      out_cnt_ff   <= out_cnt_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), out_cnt_ff, out_bytes_ff};
   assign rsp_tlast  = out_end_ff;

endmodule

// ===== tb/sv/tb_icns_channel_rle_encoder_unit.sv =====
`timescale 1ns / 1ps

module tb_icns_channel_rle_encoder_unit;

   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 300000;

   localparam int PIXEL_W           = icns_rle_pkg::PIXEL_W;
   localparam int OUT_BYTES_W       = icns_rle_pkg::OUT_BYTES_W;
   localparam int COUNT_W           = icns_rle_pkg::COUNT_W;
   localparam int RSP_DATA_W        = icns_rle_pkg::RSP_DATA_W;
   localparam int BYTE_W            = icns_rle_pkg::BYTE_W;
   localparam int WORD_BYTES        = icns_rle_pkg::WORD_BYTES;
   localparam int LITERAL_CHUNK_MAX = icns_rle_pkg::LITERAL_CHUNK_MAX;
   localparam int RUN_MAX           = icns_rle_pkg::RUN_MAX;
   localparam int RUN_MIN           = icns_rle_pkg::RUN_MIN;
   localparam logic [7:0] RUN_HDR_BASE = icns_rle_pkg::RUN_HDR_BASE;
   localparam logic [1:0] CHAN_RESET   = icns_rle_pkg::CHAN_RESET;

   typedef struct {
      logic [PIXEL_W-1:0] px;
      logic               last;
   } pixel_item_type;

   typedef struct {
      logic [OUT_BYTES_W-1:0] bytes;
      logic [COUNT_W-1:0]     count;
      logic                   fin;
   } code_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata = '0;   // [31:0] pixel_word
   logic                  req_tlast = 1'b0; // last_pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [63:0] out_bytes, [67:64] byte_count
   logic                  rsp_tlast;        // stream_end
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_wdata = '0;

   // Encoder state mirrored by the predictor
   logic [1:0]             lane_sel;
   logic [BYTE_W-1:0]      run_byte;
   int                     run_len;
   logic [BYTE_W-1:0]      lit_store [0:LITERAL_CHUNK_MAX+1];
   int                     lit_cnt;
   logic [OUT_BYTES_W-1:0] word_acc;
   int                     word_fill;

   pixel_item_type pending_pixels [$];
   code_word_type  expected_words [$];

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   bit hold_req = 1'b0;
   int hold_cyc = 0;
   int mismatch_cnt = 0;
   int cycle_cnt = 0;

   icns_channel_rle_encoder_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void emit_word(logic fin);
      code_word_type w;
      w.bytes = word_acc;
      w.count = COUNT_W'(word_fill);
      w.fin   = fin;
      expected_words.push_back(w);
      word_acc  = '0;
      word_fill = 0;
   endfunction

   function automatic void put_byte(logic [BYTE_W-1:0] b);
      if (word_fill >= WORD_BYTES) begin
         emit_word(1'b0);
      end
      word_acc  = word_acc | ({56'd0, b} << (56 - 8 * word_fill));
      word_fill = word_fill + 1;
   endfunction

   function automatic void write_chunk(int n);
      if (n == 0 || n > lit_cnt) begin
         return;
      end
      put_byte(BYTE_W'(n - 1));
      for (int k = 0; k < n; k++) begin
         put_byte(lit_store[k]);
      end
      for (int k = 0; k < lit_cnt - n; k++) begin
         lit_store[k] = lit_store[k + n];
      end
      lit_cnt = lit_cnt - n;
   endfunction

   function automatic void flush_literals();
      while (lit_cnt > 0) begin
         write_chunk((lit_cnt > LITERAL_CHUNK_MAX) ? LITERAL_CHUNK_MAX : lit_cnt);
      end
   endfunction

   function automatic void add_literal(logic [BYTE_W-1:0] b);
      if (lit_cnt < LITERAL_CHUNK_MAX + 2) begin
         lit_store[lit_cnt] = b;
         lit_cnt = lit_cnt + 1;
      end
      // a full chunk goes out as soon as it is gathered
      if (lit_cnt >= LITERAL_CHUNK_MAX) begin
         write_chunk(LITERAL_CHUNK_MAX);
      end
   endfunction

   function automatic void close_run();
      if (run_len >= RUN_MIN) begin
         flush_literals();
         put_byte(BYTE_W'(run_len - RUN_MIN) + RUN_HDR_BASE);
         put_byte(run_byte);
      end else begin
         for (int k = 0; k < run_len; k++) begin
            add_literal(run_byte);
         end
      end
      run_len = 0;
   endfunction

   function automatic void clear_encoder();
      lane_sel  = CHAN_RESET;
      run_byte  = '0;
      run_len   = 0;
      lit_cnt   = 0;
      word_acc  = '0;
      word_fill = 0;
   endfunction

   function automatic void encode_pixel(logic [PIXEL_W-1:0] px, logic last);
      logic [BYTE_W-1:0] b;
      b = px[8 * (3 - lane_sel) +: 8];
      word_acc  = '0;
      word_fill = 0;
      if (run_len != 0 && b == run_byte) begin
         run_len = run_len + 1;
      end else begin
         if (run_len != 0) begin
            close_run();
         end
         run_byte = b;
         run_len  = 1;
      end
      if (run_len >= RUN_MAX) begin
         close_run();
      end
      if (last) begin
         close_run();
         flush_literals();
         run_byte = '0;
      end
      if (word_fill > 0) begin
         emit_word(last);
      end
   endfunction

   // Stimulus helpers

   function automatic void push_raw(logic [PIXEL_W-1:0] px, logic last);
      pixel_item_type it;
      it.px   = px;
      it.last = last;
      pending_pixels.push_back(it);
   endfunction

   // place b in the encoded lane, random noise elsewhere
   function automatic void push_byte(logic [BYTE_W-1:0] b, logic last);
      logic [PIXEL_W-1:0] px;
      px = $urandom;
      px[8 * (3 - lane_sel) +: 8] = b;
      push_raw(px, last);
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return BYTE_W'($urandom);
   endfunction

   function automatic void build_stream(int n);
      int                left;
      int                kind;
      int                seg;
      logic [BYTE_W-1:0] v;
      left = n;
      while (left > 0) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            seg = $urandom_range(1, 2);
         end else if (kind < 70) begin
            seg = $urandom_range(1, 10);
         end else if (kind < 95) begin
            seg = $urandom_range(3, 20);
         end else begin
            seg = $urandom_range(126, 134);
         end
         if (seg > left) begin
            seg = left;
         end
         v = pick_byte();
         for (int k = 0; k < seg; k++) begin
            // literal stretches take a fresh byte per pixel
            if (kind >= 40 && kind < 70) begin
               v = pick_byte();
            end
            push_byte(v, left == 1);
            left = left - 1;
         end
      end
   endfunction

   function automatic void build_phase(int budget);
      int n;
      while (budget > 0) begin
         n = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 140) : $urandom_range(1, 40);
         if (n > budget) begin
            n = budget;
         end
         build_stream(n);
         budget = budget - n;
      end
   endfunction

   task automatic wait_drained();
      while (!(pending_pixels.size() == 0 && !req_tvalid && expected_words.size() == 0)) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_lane(logic [1:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      lane_sel = v;
   endtask

   // Driver: predict on each accepted transfer, then offer the next pixel
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            encode_pixel(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_pixels[0].px;
               req_tlast  <= pending_pixels[0].last;
               void'(pending_pixels.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each transfer against the oldest expected word
   always @(posedge clock) begin
      code_word_type w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual %h count %0d end %0b",
                        $time, rsp_tdata[63:0], rsp_tdata[67:64], rsp_tlast);
               mismatch_cnt <= mismatch_cnt + 1;
            end else begin
               w = expected_words.pop_front();
               if (rsp_tdata[63:0] !== w.bytes || rsp_tdata[67:64] !== w.count ||
                   rsp_tlast !== w.fin) begin
                  $display("%0t: out_bytes expected %h actual %h", $time, w.bytes,
                           rsp_tdata[63:0]);
                  $display("%0t: byte_count expected %0d actual %0d", $time, w.count,
                           rsp_tdata[67:64]);
                  $display("%0t: stream_end expected %0b actual %0b", $time, w.fin,
                           rsp_tlast);
                  mismatch_cnt <= mismatch_cnt + 1;
               end
            end
         end
         // hold off for a long stretch once, so the block backs up
         if (hold_req && hold_cyc < HOLD_CYCLES) begin
            hold_cyc   <= hold_cyc + 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clear_encoder();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Phase 0: top lane, sender idles less than receiver
      snd_idle_pct = 29;
      rcv_idle_pct = 57;
      write_lane(2'd0);
      push_raw(32'h0000_0000, 1'b1);
      push_raw(32'hFFFF_FFFF, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'h55, 1'b0);
      push_byte(8'h55, 1'b0);
      push_byte(8'hAA, 1'b1);
      for (int k = 0; k < 4; k++) begin
         push_byte(8'h7E, k == 3);
      end
      push_byte(8'h01, 1'b0);
      push_byte(8'h02, 1'b0);
      push_byte(8'h03, 1'b0);
      for (int k = 0; k < 5; k++) begin
         push_byte(8'h09, 1'b0);
      end
      push_byte(8'h04, 1'b1);
      build_phase(40);
      wait_drained();

      // Phase 1: bottom lane, idling swapped; a run that hits the cap
      snd_idle_pct = 57;
      rcv_idle_pct = 29;
      write_lane(2'd3);
      for (int k = 0; k < RUN_MAX + 1; k++) begin
         push_byte(8'hC3, 1'b0);
      end
      push_byte(8'h3C, 1'b0);
      push_byte(8'h5A, 1'b1);
      build_phase(40);
      wait_drained();

      // Phase 2: no idling; a literal stretch longer than one chunk
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_lane(2'd2);
      for (int k = 0; k < LITERAL_CHUNK_MAX + 2; k++) begin
         push_byte(BYTE_W'(k * 37 + 11), k == LITERAL_CHUNK_MAX + 1);
      end
      build_phase(30);
      wait_drained();

      // Phase 3: back to the reset lane under a long receiver hold-off
      write_lane(2'd1);
      hold_req = 1'b1;
      build_phase(65);
      wait_drained();

      if (mismatch_cnt == 0 && expected_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
